// ===== hdl/setac_pkg.sv =====
// Package: shared types, constants and arithmetic helpers for the tensor accumulator.
`default_nettype none

package setac_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SUM_WIDTH = 48;
  localparam int OUT_W     = 48;
  localparam int IN_W      = 32;
  localparam int NUM_SUMS  = 10;
  localparam int NUM_PAIRS = 6;
  localparam int TIME_OPS  = 4;
  localparam int PROD_W    = 2 * IN_W;
  localparam int QUO_W     = 64;
  // energy is positive when divided by, so its sign bit is dropped
  localparam int DEN_W     = IN_W - 1 + FRAC_BITS;
  localparam int MUL_OPS   = TIME_OPS + 3 * NUM_PAIRS;
  localparam int CNT_W     = $clog2(QUO_W);
  localparam int IDX_W     = $clog2(NUM_PAIRS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DRAIN,
    ST_DIV_INIT,
    ST_DIV,
    ST_APPLY,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    MK_TIME,
    MK_PAIR,
    MK_LO,
    MK_HI
  } mul_kind_e;

  typedef struct packed {
    logic signed [IN_W-1:0] energy;
    logic signed [IN_W-1:0] mom_x;
    logic signed [IN_W-1:0] mom_y;
    logic signed [IN_W-1:0] mom_z;
    logic [IN_W-1:0]        weight;
    logic                   start_req;
  } in_word_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] t00;
    logic signed [OUT_W-1:0] t01;
    logic signed [OUT_W-1:0] t02;
    logic signed [OUT_W-1:0] t03;
    logic signed [OUT_W-1:0] t11;
    logic signed [OUT_W-1:0] t12;
    logic signed [OUT_W-1:0] t13;
    logic signed [OUT_W-1:0] t22;
    logic signed [OUT_W-1:0] t23;
    logic signed [OUT_W-1:0] t33;
    logic                    bad_energy;
  } out_word_t;

  typedef struct packed {
    logic             load;
    logic             mul_en;
    mul_kind_e        mul_kind;
    logic [IDX_W-1:0] mul_idx;
    logic             div_init;
    logic             div_step;
    logic             apply;
    logic             out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic bad;
  } dp_status_t;

  // spatial pair k -> row / column component (0 = x, 1 = y, 2 = z)
  function automatic logic [1:0] pair_row(input logic [IDX_W-1:0] k);
    unique case (k)
      3'd0, 3'd1, 3'd2: return 2'd0;
      3'd3, 3'd4:       return 2'd1;
      default:          return 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] pair_col(input logic [IDX_W-1:0] k);
    unique case (k)
      3'd0:       return 2'd0;
      3'd1, 3'd3: return 2'd1;
      default:    return 2'd2;
    endcase
  endfunction

  // add a signed magnitude to a sum, clamping at the signed SUM_WIDTH limits
  function automatic logic signed [SUM_WIDTH-1:0] sat_add(
    input logic signed [SUM_WIDTH-1:0] s,
    input logic                        neg,
    input logic [QUO_W-1:0]            mag
  );
    logic signed [SUM_WIDTH:0] sx;
    logic signed [SUM_WIDTH:0] smax_x;
    logic signed [SUM_WIDTH:0] smin_x;
    logic [SUM_WIDTH:0]        room;
    sx     = {s[SUM_WIDTH-1], s};
    smax_x = {2'b00, {(SUM_WIDTH-1){1'b1}}};
    smin_x = {2'b11, {(SUM_WIDTH-1){1'b0}}};
    room   = neg ? (sx - smin_x) : (smax_x - sx);
    if ((QUO_W+1)'(room) < {1'b0, mag}) begin
      return neg ? smin_x[SUM_WIDTH-1:0] : smax_x[SUM_WIDTH-1:0];
    end
    return neg ? (s - mag[SUM_WIDTH-1:0]) : (s + mag[SUM_WIDTH-1:0]);
  endfunction

  function automatic logic signed [OUT_W-1:0] to_out(input logic signed [SUM_WIDTH-1:0] s);
    return OUT_W'(s);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/stress_energy_tensor_accumulator_core.sv =====
// Top level: energy-momentum tensor accumulator, controller plus datapath.
//
//  channel  | direction | handshake            | word
//  ---------+-----------+----------------------+-------------------------------
//  in       | sink      | in_valid_i/in_stall_o | in_word_i  (particle, start)
//  out      | source    | out_valid_o/out_stall_i | out_word_o (ten sums, flag)
//
//  A good particle passes from accept to result word through the shared 32x32
//  multiplier, then the six parallel bit-serial dividers, with control steps around
//  them. A particle with non-positive energy skips the multiplies and the division.
//  Reset clears the sums and all control state. A stalled result word waits in its
//  register while the next particle is taken and worked on.
`default_nettype none

module stress_energy_tensor_accumulator_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  setac_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output setac_pkg::out_word_t out_word_o
);
  import setac_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  setac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  setac_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_word_i  (in_word_i),
    .status_o   (status),
    .out_word_o (out_word_o)
  );

endmodule

`default_nettype wire

// ===== hdl/setac_div.sv =====
// Six restoring divider lanes sharing one denominator, one quotient bit per cycle while step_i is high.
`default_nettype none

module setac_div (
  input  logic                                                   clk_i,
  input  logic                                                   wr_lo_i,
  input  logic                                                   wr_hi_i,
  input  logic [setac_pkg::IDX_W-1:0]                            wr_idx_i,
  input  logic [setac_pkg::PROD_W-1:0]                           prod_i,
  input  logic [setac_pkg::DEN_W-1:0]                            den_i,
  input  logic                                                   init_i,
  input  logic                                                   step_i,
  output logic [setac_pkg::NUM_PAIRS-1:0][setac_pkg::QUO_W-1:0]  quo_o
);
  import setac_pkg::*;

  for (genvar g = 0; g < NUM_PAIRS; g++) begin : g_lane
    logic [IN_W-1:0]  hi_q;
    logic [QUO_W-1:0] lo_q;   // low numerator bits, shifted out as quotient bits shift in
    logic [DEN_W-1:0] rem_q;
    logic             ovf_q;
    logic [DEN_W:0]   sh;
    logic             fit;

    assign sh  = {rem_q, lo_q[QUO_W-1]};
    assign fit = sh >= {1'b0, den_i};

    always_ff @(posedge clk_i) begin
      if (wr_lo_i && wr_idx_i == IDX_W'(g)) begin
        hi_q <= '0;
        lo_q <= prod_i;
      end else if (wr_hi_i && wr_idx_i == IDX_W'(g)) begin
        {hi_q, lo_q[QUO_W-1:IN_W]} <= {hi_q, lo_q[QUO_W-1:IN_W]} + prod_i;
      end else if (init_i) begin
        rem_q <= DEN_W'(hi_q);
        ovf_q <= DEN_W'(hi_q) >= den_i;
      end else if (step_i) begin
        rem_q <= fit ? DEN_W'(sh - {1'b0, den_i}) : sh[DEN_W-1:0];
        lo_q  <= {lo_q[QUO_W-2:0], fit};
      end
    end

    // quotient that cannot fit 64 bits reads as all ones
    assign quo_o[g] = ovf_q ? '1 : lo_q;
  end

endmodule

`default_nettype wire

// ===== hdl/setac_dp.sv =====
// Datapath: operand capture, shared multiplier, saturating sums, divider and output register.
`default_nettype none

module setac_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  setac_pkg::ctrl_cmd_t   cmd_i,
  input  setac_pkg::in_word_t    in_word_i,
  output setac_pkg::dp_status_t  status_o,
  output setac_pkg::out_word_t   out_word_o
);
  import setac_pkg::*;

  localparam int SIDX_W = $clog2(NUM_SUMS);

  function automatic logic [IN_W-1:0] mag32(input logic [IN_W-1:0] v);
    return v[IN_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [IN_W-1:0] pick_mag(
    input logic [1:0]      sel,
    input logic [IN_W-1:0] x,
    input logic [IN_W-1:0] y,
    input logic [IN_W-1:0] z
  );
    unique case (sel)
      2'd0:    return x;
      2'd1:    return y;
      default: return z;
    endcase
  endfunction

  function automatic logic pick_neg(input logic [1:0] sel, input logic x, y, z);
    unique case (sel)
      2'd0:    return x;
      2'd1:    return y;
      default: return z;
    endcase
  endfunction

  logic [IN_W-1:0]   emag_q, magx_q, magy_q, magz_q, w_q;
  logic              negx_q, negy_q, negz_q, bad_q;
  logic [PROD_W-1:0] pp_q [NUM_PAIRS];

  logic [IN_W-1:0]   opa, opb;
  logic [PROD_W-1:0] prod_q;
  logic              pvld_q;
  mul_kind_e         pkind_q;
  logic [IDX_W-1:0]  pidx_q;

  logic signed [SUM_WIDTH-1:0] sums_q [NUM_SUMS];
  logic signed [SUM_WIDTH-1:0] sums_d [NUM_SUMS];
  logic signed [SUM_WIDTH-1:0] tnew;
  logic                        tneg;

  logic [NUM_PAIRS-1:0][QUO_W-1:0] quo;
  logic [DEN_W-1:0]                den;
  out_word_t                       out_q;

  // operand capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bad_q <= 1'b0;
    end else if (cmd_i.load) begin
      bad_q <= in_word_i.energy[IN_W-1] || (in_word_i.energy == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      emag_q <= mag32(in_word_i.energy);
      magx_q <= mag32(in_word_i.mom_x);
      magy_q <= mag32(in_word_i.mom_y);
      magz_q <= mag32(in_word_i.mom_z);
      negx_q <= in_word_i.mom_x[IN_W-1];
      negy_q <= in_word_i.mom_y[IN_W-1];
      negz_q <= in_word_i.mom_z[IN_W-1];
      w_q    <= in_word_i.weight;
    end
  end

  // shared 32x32 multiplier, result registered with its op tag
  always_comb begin
    opa = w_q;
    opb = w_q;
    unique case (cmd_i.mul_kind)
      MK_TIME: opa = (cmd_i.mul_idx == '0) ? emag_q
                   : pick_mag(2'(cmd_i.mul_idx - 1'b1), magx_q, magy_q, magz_q);
      MK_PAIR: begin
        opa = pick_mag(pair_row(cmd_i.mul_idx), magx_q, magy_q, magz_q);
        opb = pick_mag(pair_col(cmd_i.mul_idx), magx_q, magy_q, magz_q);
      end
      MK_LO:   opa = pp_q[cmd_i.mul_idx][IN_W-1:0];
      MK_HI:   opa = pp_q[cmd_i.mul_idx][PROD_W-1:IN_W];
      default: opa = w_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q <= 1'b0;
    end else begin
      pvld_q <= cmd_i.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q  <= opa * opb;
      pkind_q <= cmd_i.mul_kind;
      pidx_q  <= cmd_i.mul_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pvld_q && pkind_q == MK_PAIR) begin
      pp_q[pidx_q] <= prod_q;
    end
  end

  // time row update from the registered product
  always_comb begin
    tneg = (pidx_q == '0) ? 1'b0 : pick_neg(2'(pidx_q - 1'b1), negx_q, negy_q, negz_q);
    tnew = sat_add(sums_q[SIDX_W'(pidx_q)], tneg, prod_q >> FRAC_BITS);
  end

  always_comb begin
    sums_d = sums_q;
    priority if (cmd_i.load && in_word_i.start_req) begin
      for (int k = 0; k < NUM_SUMS; k++) begin
        sums_d[k] = '0;
      end
    end else if (pvld_q && pkind_q == MK_TIME) begin
      sums_d[SIDX_W'(pidx_q)] = tnew;
    end else if (cmd_i.apply) begin
      for (int k = 0; k < NUM_PAIRS; k++) begin
        sums_d[SIDX_W'(TIME_OPS + k)] = sat_add(
          sums_q[SIDX_W'(TIME_OPS + k)],
          pick_neg(pair_row(IDX_W'(k)), negx_q, negy_q, negz_q) ^
          pick_neg(pair_col(IDX_W'(k)), negx_q, negy_q, negz_q),
          quo[k]);
      end
    end else begin
      sums_d = sums_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_SUMS; k++) begin
        sums_q[k] <= '0;
      end
    end else begin
      sums_q <= sums_d;
    end
  end

  assign den = {emag_q[IN_W-2:0], {FRAC_BITS{1'b0}}};

  setac_div u_div (
    .clk_i    (clk_i),
    .wr_lo_i  (pvld_q && pkind_q == MK_LO),
    .wr_hi_i  (pvld_q && pkind_q == MK_HI),
    .wr_idx_i (pidx_q),
    .prod_i   (prod_q),
    .den_i    (den),
    .init_i   (cmd_i.div_init),
    .step_i   (cmd_i.div_step),
    .quo_o    (quo)
  );

  // result word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.t00        <= to_out(sums_q[0]);
      out_q.t01        <= to_out(sums_q[1]);
      out_q.t02        <= to_out(sums_q[2]);
      out_q.t03        <= to_out(sums_q[3]);
      out_q.t11        <= to_out(sums_q[4]);
      out_q.t12        <= to_out(sums_q[5]);
      out_q.t13        <= to_out(sums_q[6]);
      out_q.t22        <= to_out(sums_q[7]);
      out_q.t23        <= to_out(sums_q[8]);
      out_q.t33        <= to_out(sums_q[9]);
      out_q.bad_energy <= bad_q;
    end
  end

  assign out_word_o   = out_q;
  assign status_o.bad = bad_q;

endmodule

`default_nettype wire

// ===== hdl/setac_ctrl.sv =====
// Controller: sequences multiplies, division and result hand-off for one word at a time.
`default_nettype none

module setac_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  setac_pkg::dp_status_t  status_i,
  output setac_pkg::ctrl_cmd_t   cmd_o
);
  import setac_pkg::*;

  localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(MUL_OPS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(QUO_W - 1);
  localparam logic [CNT_W-1:0] PAIR_BASE = CNT_W'(TIME_OPS);
  localparam logic [CNT_W-1:0] LO_BASE   = CNT_W'(TIME_OPS + NUM_PAIRS);
  localparam logic [CNT_W-1:0] HI_BASE   = CNT_W'(TIME_OPS + 2 * NUM_PAIRS);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             can_load;

  assign can_load = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) state_d = ST_MUL;
      end
      ST_MUL: begin
        if (status_i.bad) begin
          state_d = ST_OUT;
        end else if (cnt_q == MUL_LAST) begin
          cnt_d   = '0;
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DRAIN:    state_d = ST_DIV_INIT;
      ST_DIV_INIT: state_d = ST_DIV;
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          cnt_d   = '0;
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: state_d = ST_OUT;
      ST_OUT: begin
        if (can_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.mul_kind = MK_TIME;
    unique case (state_q)
      ST_IDLE: cmd_o.load = in_valid_i;
      ST_MUL: begin
        cmd_o.mul_en = !status_i.bad;
        priority if (cnt_q < PAIR_BASE) begin
          cmd_o.mul_kind = MK_TIME;
          cmd_o.mul_idx  = IDX_W'(cnt_q);
        end else if (cnt_q < LO_BASE) begin
          cmd_o.mul_kind = MK_PAIR;
          cmd_o.mul_idx  = IDX_W'(cnt_q - PAIR_BASE);
        end else if (cnt_q < HI_BASE) begin
          cmd_o.mul_kind = MK_LO;
          cmd_o.mul_idx  = IDX_W'(cnt_q - LO_BASE);
        end else begin
          cmd_o.mul_kind = MK_HI;
          cmd_o.mul_idx  = IDX_W'(cnt_q - HI_BASE);
        end
      end
      ST_DRAIN:    cmd_o.load = 1'b0;
      ST_DIV_INIT: cmd_o.div_init = 1'b1;
      ST_DIV:      cmd_o.div_step = 1'b1;
      ST_APPLY:    cmd_o.apply = 1'b1;
      ST_OUT:      cmd_o.out_load = can_load;
      default:     cmd_o.load = 1'b0;
    endcase
  end

  assign out_valid_d = cmd_o.out_load || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;
  assign in_stall_o  = (state_q != ST_IDLE);

  // a waiting result word is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result word overwritten while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_MUL))
    else $error("accepted word did not start the multiply sequence");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL && status_i.bad) |-> !cmd_o.mul_en)
    else $error("multiply issued for a particle with bad energy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |=> cmd_o.div_init)
    else $error("divider not initialized after last product");

endmodule

`default_nettype wire
